// ===== rtl/core/cl_pkg.sv =====
// Shared types and constants of the cell list maintenance block.
package cl_pkg;

    localparam int MAX_CELLS   = 4096;
    localparam int MAX_MEMBERS = 4096;
    localparam int CELL_W      = $clog2(MAX_CELLS);
    localparam int MEM_W       = $clog2(MAX_MEMBERS);
    localparam int POS_W       = 20;
    localparam int INV_W       = 16;
    localparam int COORD_W     = 10;
    localparam int OUT_CELL_W  = 12;

    // register indexes
    localparam logic [1:0] REG_CELLS_XY    = 2'd0;
    localparam logic [1:0] REG_CELLS_Z     = 2'd1;
    localparam logic [1:0] REG_INV_CELL_XY = 2'd2;
    localparam logic [1:0] REG_INV_CELL_Z  = 2'd3;

    // request modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_MOVE   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_RANGE   = 2'd1;
    localparam logic [1:0] ERR_MISSING = 2'd2;
    localparam logic [1:0] ERR_DUP     = 2'd3;

    typedef struct packed {
        logic [4:0]       cells_xy;
        logic [4:0]       cells_z;
        logic [INV_W-1:0] inv_xy;
        logic [INV_W-1:0] inv_z;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [MEM_W-1:0] idx;
    } entry_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_INSERT = 2'd2,
        OP_MOVE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [MEM_W-1:0]      member;
        logic [CELL_W-1:0]     dst_cell;
        logic [CELL_W-1:0]     src_cell;
        logic [OUT_CELL_W-1:0] res_cell;
        logic [1:0]            res_err;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic sweeping;
        logic pop;
    } b_stat_t;

endpackage

// ===== rtl/core/cl_ifs.sv =====
// Request, result and configuration channel interfaces.
interface cl_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] member;
    logic [19:0] new_x;
    logic [19:0] new_y;
    logic [19:0] new_z;
    logic [19:0] old_x;
    logic [19:0] old_y;
    logic [19:0] old_z;
    modport source(output valid, mode, member, new_x, new_y, new_z, old_x, old_y, old_z,
                   input ready);
    modport sink(input valid, mode, member, new_x, new_y, new_z, old_x, old_y, old_z,
                 output ready);
endinterface

interface cl_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] cell_index;
    logic [1:0]  error_code;
    modport source(output valid, cell_index, error_code, input ready);
    modport sink(input valid, cell_index, error_code, output ready);
endinterface

interface cl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/cl_front.sv =====
// Front end: accepts requests, computes cell indexes and classifies them.
module cl_front (
    input  logic              clk,
    input  logic              rst_n,
    cl_item_if.sink           item,
    input  cl_pkg::cfg_t      cfg,
    input  cl_pkg::q_stat_t   q_stat,
    output logic              push,
    output cl_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL1 = 4'b0010,
        F_MUL2 = 4'b0100,
        F_SUM  = 4'b1000
    } f_state_t;

    localparam int TY_W  = cl_pkg::COORD_W + 5;
    localparam int TZ_W  = cl_pkg::COORD_W + 10;
    localparam int SUM_W = TZ_W + 1;
    localparam int PROD_W = cl_pkg::POS_W + cl_pkg::INV_W;

    f_state_t state_reg, state_next;

    logic [1:0]                    mode_reg;
    logic [cl_pkg::MEM_W-1:0]      member_reg;
    logic [cl_pkg::POS_W-1:0]      pos_reg [6];
    logic [cl_pkg::COORD_W-1:0]    coord_reg [6];
    logic [9:0]                    xysq_reg;
    logic [14:0]                   ncell_reg;
    logic [TY_W-1:0]               ty_reg [2];
    logic [TZ_W-1:0]               tz_reg [2];

    logic [SUM_W-1:0] cn, co;
    logic             ok_n, ok_o;
    logic [PROD_W-1:0] prod [6];

    function automatic logic [cl_pkg::OUT_CELL_W-1:0] sat(input logic [SUM_W-1:0] c);
        if (c > SUM_W'(4095))
            sat = 12'd4095;
        else
            sat = c[cl_pkg::OUT_CELL_W-1:0];
    endfunction

    assign item.ready = (state_reg == F_IDLE);

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            if (i == 2 || i == 5)
                prod[i] = PROD_W'(pos_reg[i]) * PROD_W'(cfg.inv_z);
            else
                prod[i] = PROD_W'(pos_reg[i]) * PROD_W'(cfg.inv_xy);
        end
    end

    always_comb
    begin
        cn = SUM_W'(coord_reg[0]) + SUM_W'(ty_reg[0]) + SUM_W'(tz_reg[0]);
        co = SUM_W'(coord_reg[3]) + SUM_W'(ty_reg[1]) + SUM_W'(tz_reg[1]);
        ok_n = (cn < SUM_W'(ncell_reg)) && (cn < SUM_W'(cl_pkg::MAX_CELLS));
        ok_o = (co < SUM_W'(ncell_reg)) && (co < SUM_W'(cl_pkg::MAX_CELLS));
    end

    always_comb
    begin
        cmd.member   = member_reg;
        cmd.dst_cell = cn[cl_pkg::CELL_W-1:0];
        cmd.src_cell = co[cl_pkg::CELL_W-1:0];
        cmd.op       = cl_pkg::OP_NONE;
        cmd.res_cell = '0;
        cmd.res_err  = cl_pkg::ERR_OK;
        unique case (mode_reg)
            cl_pkg::MODE_CLEAR:
            begin
                cmd.op = cl_pkg::OP_CLEAR;
            end
            cl_pkg::MODE_INSERT:
            begin
                if (ok_n)
                begin
                    cmd.op       = cl_pkg::OP_INSERT;
                    cmd.res_cell = cn[cl_pkg::OUT_CELL_W-1:0];
                end
                else
                begin
                    cmd.res_cell = sat(cn);
                    cmd.res_err  = cl_pkg::ERR_RANGE;
                end
            end
            cl_pkg::MODE_MOVE:
            begin
                if (!ok_n || !ok_o)
                begin
                    cmd.res_cell = sat(cn);
                    cmd.res_err  = cl_pkg::ERR_RANGE;
                end
                else
                begin
                    cmd.res_cell = cn[cl_pkg::OUT_CELL_W-1:0];
                    if (cn != co)
                        cmd.op = cl_pkg::OP_MOVE;
                end
            end
            default:
            begin
                cmd.op = cl_pkg::OP_NONE;
            end
        endcase
    end

    assign push = (state_reg == F_SUM) && !q_stat.full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (item.valid) state_next = F_MUL1;
            F_MUL1: state_next = F_MUL2;
            F_MUL2: state_next = F_SUM;
            F_SUM:  if (!q_stat.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && item.valid)
        begin
            mode_reg   <= item.mode;
            member_reg <= item.member;
            pos_reg[0] <= item.new_x;
            pos_reg[1] <= item.new_y;
            pos_reg[2] <= item.new_z;
            pos_reg[3] <= item.old_x;
            pos_reg[4] <= item.old_y;
            pos_reg[5] <= item.old_z;
        end
        if (state_reg == F_MUL1)
        begin
            for (int i = 0; i < 6; i++)
                coord_reg[i] <= prod[i][PROD_W-1:26];
            xysq_reg <= 10'(cfg.cells_xy) * 10'(cfg.cells_xy);
        end
        if (state_reg == F_MUL2)
        begin
            ty_reg[0] <= TY_W'(coord_reg[1]) * TY_W'(cfg.cells_xy);
            ty_reg[1] <= TY_W'(coord_reg[4]) * TY_W'(cfg.cells_xy);
            tz_reg[0] <= TZ_W'(coord_reg[2]) * TZ_W'(xysq_reg);
            tz_reg[1] <= TZ_W'(coord_reg[5]) * TZ_W'(xysq_reg);
            ncell_reg <= 15'(xysq_reg) * 15'(cfg.cells_z);
        end
    end

endmodule

// ===== rtl/core/cl_queue.sv =====
// Two-entry command queue between front and back end.
module cl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cl_pkg::cmd_t     push_cmd,
    input  logic             pop,
    output cl_pkg::cmd_t     head_cmd,
    output cl_pkg::q_stat_t  q_stat
);

    cl_pkg::cmd_t slot_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign head_cmd     = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/core/cl_back.sv =====
// Back end: head and link memories, list walks, result register.
module cl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cl_pkg::cmd_t     head_cmd,
    input  cl_pkg::q_stat_t  q_stat,
    output cl_pkg::b_stat_t  b_stat,
    cl_result_if.source      result
);

    typedef enum logic [13:0] {
        B_SWEEP     = 14'b00000000000001,
        B_IDLE      = 14'b00000000000010,
        B_INS_RD    = 14'b00000000000100,
        B_INS_WR    = 14'b00000000001000,
        B_U_HEAD    = 14'b00000000010000,
        B_U_HEADW   = 14'b00000000100000,
        B_U_HEADFIX = 14'b00000001000000,
        B_U_WALK    = 14'b00000010000000,
        B_U_LINKFIX = 14'b00000100000000,
        B_U_LINKCLR = 14'b00001000000000,
        B_A_HEAD    = 14'b00010000000000,
        B_A_HEADW   = 14'b00100000000000,
        B_A_WALK    = 14'b01000000000000,
        B_A_CLR     = 14'b10000000000000
    } b_state_t;

    b_state_t state_reg, state_next;

    cl_pkg::entry_t heads [cl_pkg::MAX_CELLS];
    cl_pkg::entry_t links [cl_pkg::MAX_MEMBERS];
    cl_pkg::entry_t h_q, l_q, h_wd, l_wd;
    logic                     h_we, l_we;
    logic [cl_pkg::CELL_W-1:0] h_wa, h_ra;
    logic [cl_pkg::MEM_W-1:0]  l_wa, l_ra;

    cl_pkg::cmd_t             cmd_reg, cmd_next;
    logic [cl_pkg::MEM_W-1:0] cur_reg, cur_next;
    logic [cl_pkg::MEM_W-1:0] cnt_reg, cnt_next;
    logic [1:0]               err_reg, err_next;
    logic                     clr_reg, clr_next;
    logic                     out_valid_reg, out_valid_next;
    logic [11:0]              out_cell_reg, out_cell_next;
    logic [1:0]               out_err_reg, out_err_next;
    logic                     pop;

    function automatic logic is_m(input cl_pkg::entry_t e, input logic [cl_pkg::MEM_W-1:0] m);
        is_m = e.valid && (e.idx == m);
    endfunction

    always_ff @(posedge clk)
    begin
        if (h_we)
            heads[h_wa] <= h_wd;
        h_q <= heads[h_ra];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
            links[l_wa] <= l_wd;
        l_q <= links[l_ra];
    end

    assign result.valid      = out_valid_reg;
    assign result.cell_index = out_cell_reg;
    assign result.error_code = out_err_reg;
    assign b_stat.sweeping   = (state_reg == B_SWEEP);
    assign b_stat.pop        = pop;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_cell_next  = out_cell_reg;
        out_err_next   = out_err_reg;
        pop  = 1'b0;
        h_we = 1'b0;
        h_wa = cmd_reg.dst_cell;
        h_wd = '0;
        h_ra = cmd_reg.dst_cell;
        l_we = 1'b0;
        l_wa = cmd_reg.member;
        l_wd = '0;
        l_ra = cur_reg;
        unique case (state_reg)
            B_SWEEP:
            begin
                h_we = 1'b1;
                h_wa = cnt_reg;
                l_we = 1'b1;
                l_wa = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cl_pkg::MEM_W'(cl_pkg::MAX_MEMBERS - 1))
                begin
                    state_next = B_IDLE;
                    if (clr_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_cell_next  = cmd_reg.res_cell;
                        out_err_next   = cl_pkg::ERR_OK;
                    end
                end
            end
            B_IDLE:
            begin
                if (!q_stat.empty && !out_valid_reg)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    err_next = cl_pkg::ERR_OK;
                    unique case (head_cmd.op)
                        cl_pkg::OP_CLEAR:
                        begin
                            clr_next   = 1'b1;
                            cnt_next   = '0;
                            state_next = B_SWEEP;
                        end
                        cl_pkg::OP_INSERT: state_next = B_INS_RD;
                        cl_pkg::OP_MOVE:   state_next = B_U_HEAD;
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_cell_next  = head_cmd.res_cell;
                            out_err_next   = head_cmd.res_err;
                        end
                    endcase
                end
            end
            B_INS_RD:
            begin
                state_next = B_INS_WR;
            end
            B_INS_WR:
            begin
                l_we = 1'b1;
                l_wd = h_q;
                h_we = 1'b1;
                h_wd = '{valid: 1'b1, idx: cmd_reg.member};
                out_valid_next = 1'b1;
                out_cell_next  = cmd_reg.res_cell;
                out_err_next   = cl_pkg::ERR_OK;
                state_next     = B_IDLE;
            end
            B_U_HEAD:
            begin
                h_ra = cmd_reg.src_cell;
                state_next = B_U_HEADW;
            end
            B_U_HEADW:
            begin
                if (!h_q.valid)
                begin
                    err_next   = cl_pkg::ERR_MISSING;
                    state_next = B_A_HEAD;
                end
                else if (is_m(h_q, cmd_reg.member))
                begin
                    l_ra       = cmd_reg.member;
                    state_next = B_U_HEADFIX;
                end
                else
                begin
                    cur_next   = h_q.idx;
                    l_ra       = h_q.idx;
                    cnt_next   = '0;
                    state_next = B_U_WALK;
                end
            end
            B_U_HEADFIX:
            begin
                h_we = 1'b1;
                h_wa = cmd_reg.src_cell;
                h_wd = l_q;
                l_we = 1'b1;
                state_next = B_A_HEAD;
            end
            B_U_WALK:
            begin
                if (is_m(l_q, cmd_reg.member))
                begin
                    l_ra       = cmd_reg.member;
                    state_next = B_U_LINKFIX;
                end
                else if (!l_q.valid ||
                         cnt_reg == cl_pkg::MEM_W'(cl_pkg::MAX_MEMBERS - 1))
                begin
                    err_next   = cl_pkg::ERR_MISSING;
                    state_next = B_A_HEAD;
                end
                else
                begin
                    cur_next = l_q.idx;
                    l_ra     = l_q.idx;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_U_LINKFIX:
            begin
                l_we = 1'b1;
                l_wa = cur_reg;
                l_wd = l_q;
                state_next = B_U_LINKCLR;
            end
            B_U_LINKCLR:
            begin
                l_we = 1'b1;
                state_next = B_A_HEAD;
            end
            B_A_HEAD:
            begin
                state_next = B_A_HEADW;
            end
            B_A_HEADW:
            begin
                if (!h_q.valid)
                begin
                    h_we = 1'b1;
                    h_wd = '{valid: 1'b1, idx: cmd_reg.member};
                    l_we = 1'b1;
                    out_valid_next = 1'b1;
                    out_cell_next  = cmd_reg.res_cell;
                    out_err_next   = err_reg;
                    state_next     = B_IDLE;
                end
                else if (is_m(h_q, cmd_reg.member))
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = cmd_reg.res_cell;
                    out_err_next   = cl_pkg::ERR_DUP;
                    state_next     = B_IDLE;
                end
                else
                begin
                    cur_next   = h_q.idx;
                    l_ra       = h_q.idx;
                    cnt_next   = '0;
                    state_next = B_A_WALK;
                end
            end
            B_A_WALK:
            begin
                if (is_m(l_q, cmd_reg.member))
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = cmd_reg.res_cell;
                    out_err_next   = cl_pkg::ERR_DUP;
                    state_next     = B_IDLE;
                end
                else if (!l_q.valid)
                begin
                    l_we = 1'b1;
                    l_wa = cur_reg;
                    l_wd = '{valid: 1'b1, idx: cmd_reg.member};
                    state_next = B_A_CLR;
                end
                else if (cnt_reg == cl_pkg::MEM_W'(cl_pkg::MAX_MEMBERS - 1))
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = cmd_reg.res_cell;
                    out_err_next   = cl_pkg::ERR_DUP;
                    state_next     = B_IDLE;
                end
                else
                begin
                    cur_next = l_q.idx;
                    l_ra     = l_q.idx;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_A_CLR:
            begin
                l_we = 1'b1;
                out_valid_next = 1'b1;
                out_cell_next  = cmd_reg.res_cell;
                out_err_next   = err_reg;
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            cnt_reg       <= '0;
            clr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cur_reg      <= cur_next;
        err_reg      <= err_next;
        out_cell_reg <= out_cell_next;
        out_err_reg  <= out_err_next;
    end

endmodule

// ===== rtl/core/cell_list_maintenance.sv =====
// Top level of the cell list maintenance block.
// Keeps a spatial cell list (one head per cell, one next-link per member) in
// two 4096-entry memories and answers one result per request. After reset the
// block sweeps both memories before the first request is carried out;
// configuration writes are taken at any time. A request passes the front end
// (capture, two multiply stages, index sum and classification) and then
// waits in a two-entry queue, so the front takes the next request while the
// back end still works. In the back end a range error, an unused mode or an
// unchanged cell is answered straight from idle, an insert reads and rewrites
// the cell head, a clear sweeps both memories (one memory row a cycle), and
// a move walks the old cell's list and the new one; the single read port of
// the link memory sets the pace of those walks. The back end starts a
// request only when the result register is empty, so each result must be
// taken before the next start.
module cell_list_maintenance (
    input  logic         clk,
    input  logic         rst_n,
    cl_item_if.sink      item,
    cl_result_if.source  result,
    cl_cfg_if.sink       cfg
);

    cl_pkg::cfg_t    cfg_reg;
    cl_pkg::cmd_t    push_cmd, head_cmd;
    cl_pkg::q_stat_t q_stat;
    cl_pkg::b_stat_t b_stat;
    logic            push;

    // configuration writes are always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cells_xy <= 5'd8;
            cfg_reg.cells_z  <= 5'd8;
            cfg_reg.inv_xy   <= 16'd4096;
            cfg_reg.inv_z    <= 16'd4096;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cl_pkg::REG_CELLS_XY:    cfg_reg.cells_xy <= cfg.data[4:0];
                cl_pkg::REG_CELLS_Z:     cfg_reg.cells_z  <= cfg.data[4:0];
                cl_pkg::REG_INV_CELL_XY: cfg_reg.inv_xy   <= cfg.data;
                cl_pkg::REG_INV_CELL_Z:  cfg_reg.inv_z    <= cfg.data;
                default:                 cfg_reg          <= cfg_reg;
            endcase
        end
    end

    cl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .push   (push),
        .cmd    (push_cmd)
    );

    cl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (b_stat.pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    cl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .b_stat   (b_stat),
        .result   (result)
    );

    // queue never written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command queue overflow");

    // back end never takes from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.pop |-> !q_stat.empty)
        else $error("command queue underflow");

    // no result is shown while the memories are swept
    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.sweeping |-> !result.valid)
        else $error("result during memory sweep");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the cell list maintenance block.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;   // mode three: ignored by the block
    localparam int POOL = 64;                    // members used by well-formed traffic
    localparam int PHASE_ITEMS = 220;

    typedef struct {
        logic [1:0]  mode;
        logic [11:0] member;
        logic [19:0] nx, ny, nz, ox, oy, oz;
        bit          typed;     // expected result typed in below
        logic [11:0] cidx;
        logic [1:0]  err;
    } dir_row_t;

    typedef struct {
        logic [11:0] cidx;
        logic [1:0]  err;
    } cell_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cl_item_if   item_ch();
    cl_result_if res_ch();
    cl_cfg_if    cfg_ch();

    cell_list_maintenance u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // predictor copy of the block's state and registers
    logic [4:0]  cl_xy = 5'd8;
    logic [4:0]  cl_z = 5'd8;
    logic [15:0] inv_xy = 16'd4096;
    logic [15:0] inv_z = 16'd4096;
    logic [12:0] heads [cl_pkg::MAX_CELLS];
    logic [12:0] links [cl_pkg::MAX_MEMBERS];

    cell_res_t pending_cells[$];   // expected results, oldest first
    int mismatches = 0;
    int results_seen = 0;
    int sent = 0;
    int snd_idle = 35;
    int rcv_idle = 72;
    int n_err [4] = '{0, 0, 0, 0};

    // stimulus-side bookkeeping: where each pool member sits
    logic [19:0] px [POOL];
    logic [19:0] py [POOL];
    logic [19:0] pz [POOL];
    bit          placed [POOL];

    function automatic longint axis_of(logic [19:0] pos, logic [15:0] inv);
        return (longint'(pos) * longint'(inv)) >>> 26;
    endfunction

    function automatic longint cell_at(logic [19:0] x, logic [19:0] y, logic [19:0] z);
        longint xy;
        xy = longint'(cl_xy);
        return axis_of(x, inv_xy) + axis_of(y, inv_xy) * xy + axis_of(z, inv_z) * xy * xy;
    endfunction

    function automatic bit cell_valid(longint c);
        longint n;
        n = longint'(cl_xy) * longint'(cl_xy) * longint'(cl_z);
        return c < n && c < cl_pkg::MAX_CELLS;
    endfunction

    function automatic bit holds(logic [12:0] e, logic [11:0] m);
        return e[12] && e[11:0] == m;
    endfunction

    // remove m from the list of cell c; 1 when found
    function automatic bit drop_member(int c, logic [11:0] m);
        logic [12:0] e;
        logic [11:0] cur;
        e = heads[c];
        if (!e[12])
            return 1'b0;
        if (holds(e, m))
        begin
            heads[c] = links[m];
            links[m] = '0;
            return 1'b1;
        end
        for (int s = 0; s < cl_pkg::MAX_MEMBERS && e[12]; s++)
        begin
            cur = e[11:0];
            if (holds(links[cur], m))
            begin
                links[cur] = links[m];
                links[m] = '0;
                return 1'b1;
            end
            e = links[cur];
        end
        return 1'b0;
    endfunction

    // append m at the tail of cell c; 1 on a duplicate or a runaway walk
    function automatic bit tail_append(int c, logic [11:0] m);
        logic [12:0] e, nx;
        e = heads[c];
        if (!e[12])
        begin
            heads[c] = {1'b1, m};
            links[m] = '0;
            return 1'b0;
        end
        if (holds(e, m))
            return 1'b1;
        for (int s = 0; s < cl_pkg::MAX_MEMBERS; s++)
        begin
            nx = links[e[11:0]];
            if (holds(nx, m))
                return 1'b1;
            if (!nx[12])
            begin
                links[e[11:0]] = {1'b1, m};
                links[m] = '0;
                return 1'b0;
            end
            e = nx;
        end
        return 1'b1;
    endfunction

    function automatic cell_res_t predict_cell(dir_row_t r);
        cell_res_t res;
        longint cn, co;
        res.cidx = '0;
        res.err = cl_pkg::ERR_OK;
        if (r.mode == cl_pkg::MODE_CLEAR)
        begin
            for (int i = 0; i < cl_pkg::MAX_CELLS; i++)
                heads[i] = '0;
            for (int i = 0; i < cl_pkg::MAX_MEMBERS; i++)
                links[i] = '0;
            return res;
        end
        if (r.mode == MODE_UNUSED)
            return res;
        cn = cell_at(r.nx, r.ny, r.nz);
        if (r.mode == cl_pkg::MODE_INSERT)
        begin
            if (!cell_valid(cn))
            begin
                res.cidx = cn > 4095 ? 12'd4095 : cn[11:0];
                res.err = cl_pkg::ERR_RANGE;
                return res;
            end
            links[r.member] = heads[cn];
            heads[cn] = {1'b1, r.member};
            res.cidx = cn[11:0];
            return res;
        end
        co = cell_at(r.ox, r.oy, r.oz);
        if (!cell_valid(cn) || !cell_valid(co))
        begin
            res.cidx = cn > 4095 ? 12'd4095 : cn[11:0];
            res.err = cl_pkg::ERR_RANGE;
            return res;
        end
        res.cidx = cn[11:0];
        if (cn == co)
            return res;
        if (!drop_member(int'(co), r.member))
            res.err = cl_pkg::ERR_MISSING;
        if (tail_append(int'(cn), r.member))
            res.err = cl_pkg::ERR_DUP;
        return res;
    endfunction

    // random position along one axis, mostly inside the configured grid
    function automatic logic [19:0] axis_pos(int n, logic [15:0] inv);
        longint lim;
        if (inv == 0 || $urandom_range(99) < 6)
            return 20'($urandom);
        lim = ((longint'(n) << 26) - 1) / inv;
        if (lim > 1048575)
            lim = 1048575;
        return 20'($urandom_range(0, int'(lim)));
    endfunction

    // drive one request, wait for its handshake, record the expectation;
    // valid stays high on return so the next request can follow directly
    task automatic push_request(dir_row_t r);
        cell_res_t exp_res;
        while ($urandom_range(99) < snd_idle)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.mode   <= r.mode;
        item_ch.member <= r.member;
        item_ch.new_x  <= r.nx;
        item_ch.new_y  <= r.ny;
        item_ch.new_z  <= r.nz;
        item_ch.old_x  <= r.ox;
        item_ch.old_y  <= r.oy;
        item_ch.old_z  <= r.oz;
        do
            @(posedge clk);
        while (!item_ch.ready);
        exp_res = predict_cell(r);
        if (r.typed)
        begin
            exp_res.cidx = r.cidx;
            exp_res.err = r.err;
        end
        pending_cells.push_back(exp_res);
        sent++;
        if (sent == 370)
        begin
            snd_idle = 72;
            rcv_idle = 35;
        end
        else if (sent == 740)
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        @(negedge clk);
    endtask

    // valid stays high on return; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            cl_pkg::REG_CELLS_XY:    cl_xy = value[4:0];
            cl_pkg::REG_CELLS_Z:     cl_z = value[4:0];
            cl_pkg::REG_INV_CELL_XY: inv_xy = value;
            cl_pkg::REG_INV_CELL_Z:  inv_z = value;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    // one random request: mostly inserts and moves of tracked pool members
    task automatic random_request();
        dir_row_t r;
        int pick, k;
        pick = $urandom_range(99);
        k = $urandom_range(POOL - 1);
        r = '{mode: cl_pkg::MODE_MOVE, member: 12'(k), typed: 1'b0, cidx: '0, err: '0,
              nx: axis_pos(cl_xy, inv_xy), ny: axis_pos(cl_xy, inv_xy),
              nz: axis_pos(cl_z, inv_z),
              ox: axis_pos(cl_xy, inv_xy), oy: axis_pos(cl_xy, inv_xy),
              oz: axis_pos(cl_z, inv_z)};
        if (pick < 1)
            r.mode = cl_pkg::MODE_CLEAR;
        else if (pick < 4)
        begin
            r.mode = MODE_UNUSED;
            r.member = 12'($urandom);
        end
        else if (pick < 12)
        begin
            // noise: any member, stale or random old position
            r.mode = $urandom_range(1) ? cl_pkg::MODE_INSERT : cl_pkg::MODE_MOVE;
            r.member = 12'($urandom);
            r.ox = 20'($urandom);
        end
        else if (!placed[k])
            r.mode = cl_pkg::MODE_INSERT;
        else
        begin
            r.ox = px[k];
            r.oy = py[k];
            r.oz = pz[k];
            if ($urandom_range(3) == 0)
            begin
                // stay in the same cell now and then
                r.nx = px[k];
                r.ny = py[k];
                r.nz = pz[k];
            end
        end
        push_request(r);
        if (r.mode == cl_pkg::MODE_CLEAR)
            placed = '{default: 1'b0};
        else if (r.member < POOL && r.mode != MODE_UNUSED
                 && cell_valid(cell_at(r.nx, r.ny, r.nz)))
        begin
            placed[r.member] = 1'b1;
            px[r.member] = r.nx;
            py[r.member] = r.ny;
            pz[r.member] = r.nz;
        end
    endtask

    // receiver: ready changes on the falling edge
    always @(negedge clk)
        res_ch.ready <= rst_n && ($urandom_range(99) >= rcv_idle);

    // result checker
    always @(posedge clk)
    begin
        cell_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (pending_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result cell=%0d err=%0d",
                             res_ch.cell_index, res_ch.error_code);
            end
            else
            begin
                want = pending_cells.pop_front();
                n_err[want.err]++;
                if (res_ch.cell_index !== want.cidx || res_ch.error_code !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: result %0d mismatch: cell %0d/%0d err %0d/%0d (exp/got)",
                                 results_seen, want.cidx, res_ch.cell_index,
                                 want.err, res_ch.error_code);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        dir_row_t dir_rows [12];
        logic [15:0] cfg_sets [5][4];

        // reset-time grid is 8x8x8 with cell length 16384 position units: axis = pos >> 14
        dir_rows = '{
            '{cl_pkg::MODE_INSERT, 12'd0, 20'h0, 20'h0, 20'h0, 0, 0, 0,
              1, 12'd0, cl_pkg::ERR_OK},
            // all-ones position lands past the grid: saturated index
            '{cl_pkg::MODE_INSERT, 12'd4095, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0, 0, 0,
              1, 12'd4095, cl_pkg::ERR_RANGE},
            '{cl_pkg::MODE_INSERT, 12'd1, 20'h04000, 20'h0, 20'h0, 0, 0, 0,
              1, 12'd1, cl_pkg::ERR_OK},
            // move to cell 0 behind member 0
            '{cl_pkg::MODE_MOVE, 12'd1, 20'h0, 20'h0, 20'h0, 20'h04000, 0, 0,
              1, 12'd0, cl_pkg::ERR_OK},
            // unchanged cell
            '{cl_pkg::MODE_MOVE, 12'd0, 20'h0, 20'h0, 20'h0, 20'h0, 0, 0,
              1, 12'd0, cl_pkg::ERR_OK},
            // not in old cell, still appended
            '{cl_pkg::MODE_MOVE, 12'd7, 20'h04000, 0, 0, 20'h08000, 0, 0,
              1, 12'd1, cl_pkg::ERR_MISSING},
            // already in new cell (and missing from old): duplicate wins
            '{cl_pkg::MODE_MOVE, 12'd1, 20'h0, 0, 0, 20'h0C000, 0, 0,
              1, 12'd0, cl_pkg::ERR_DUP},
            '{MODE_UNUSED, 12'hFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
              20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1, 12'd0, cl_pkg::ERR_OK},
            // old cell out of range
            '{cl_pkg::MODE_MOVE, 12'd0, 20'h0, 20'h0, 20'h0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
              1, 12'd0, cl_pkg::ERR_RANGE},
            '{cl_pkg::MODE_CLEAR, 12'hFFF, 20'hFFFFF, 0, 0, 0, 0, 0,
              1, 12'd0, cl_pkg::ERR_OK},
            // far corner of the grid
            '{cl_pkg::MODE_INSERT, 12'd5, 20'h1FFFF, 20'h1FFFF, 20'h1FFFF, 0, 0, 0,
              1, 12'd511, cl_pkg::ERR_OK},
            '{cl_pkg::MODE_MOVE, 12'd5, 20'h0, 20'h1FFFF, 20'h0, 20'h1FFFF, 20'h1FFFF, 20'h1FFFF,
              0, 12'd0, cl_pkg::ERR_OK}
        };
        // cells_xy, cells_z, inv_xy, inv_z per phase; extremes included
        cfg_sets = '{
            '{16'd8,  16'd8,  16'd4096,  16'd4096},
            '{16'd16, 16'd16, 16'd65535, 16'd65535},
            '{16'd1,  16'd1,  16'd0,     16'd0},
            '{16'd2,  16'd1,  16'd20000, 16'd300},
            '{16'd3,  16'd16, 16'd1,     16'd65535}
        };

        item_ch.valid = 1'b0;
        item_ch.mode = cl_pkg::MODE_CLEAR;
        item_ch.member = '0;
        item_ch.new_x = '0;
        item_ch.new_y = '0;
        item_ch.new_z = '0;
        item_ch.old_x = '0;
        item_ch.old_y = '0;
        item_ch.old_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = cl_pkg::REG_CELLS_XY;
        cfg_ch.data = '0;
        for (int i = 0; i < cl_pkg::MAX_CELLS; i++)
            heads[i] = '0;
        for (int i = 0; i < cl_pkg::MAX_MEMBERS; i++)
            links[i] = '0;
        placed = '{default: 1'b0};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(cl_pkg::REG_CELLS_XY, cfg_sets[ph][0]);
            write_reg(cl_pkg::REG_CELLS_Z, cfg_sets[ph][1]);
            write_reg(cl_pkg::REG_INV_CELL_XY, cfg_sets[ph][2]);
            write_reg(cl_pkg::REG_INV_CELL_Z, cfg_sets[ph][3]);
            cfg_ch.valid <= 1'b0;
            if (ph == 0)
            begin
                foreach (dir_rows[i])
                    push_request(dir_rows[i]);
            end
            // start each grid from empty lists
            push_request('{cl_pkg::MODE_CLEAR, 12'd0, 0, 0, 0, 0, 0, 0, 0, 12'd0,
                           cl_pkg::ERR_OK});
            placed = '{default: 1'b0};
            for (int i = 0; i < (ph == 2 ? 60 : PHASE_ITEMS + 25); i++)
                random_request();
        end

        item_ch.valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("tb: %0d requests over 5 grid settings, %0d results", sent, results_seen);
        $display("tb: ok %0d, range %0d, missing %0d, duplicate %0d",
                 n_err[0], n_err[1], n_err[2], n_err[3]);
        if (mismatches == 0 && pending_cells.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
